// ===== src/mlcd_pkg.sv =====
// ----------------------------------------------------------------------------
// mlcd_pkg
// Shared types, codes and helpers of the memory LCD frame serializer.
// ----------------------------------------------------------------------------
package mlcd_pkg;

  localparam logic [1:0] ACT_PIXEL = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic CFG_ROW_BYTES  = 1'b0;
  localparam logic CFG_LINE_COUNT = 1'b1;

  localparam logic [7:0] CMD_WRITE = 8'b1000_0000;
  localparam logic [7:0] CMD_CLEAR = 8'b0000_0100;

  localparam int NUM_SLOTS = 5;
  localparam int SLOT_CMD  = 0;
  localparam int SLOT_LINE = 1;
  localparam int SLOT_DATA = 2;
  localparam int SLOT_PAD  = 3;
  localparam int SLOT_END  = 4;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic                 clear;
    logic                 tick;
    logic                 vcom;
    logic [7:0]           line_byte;
    logic [7:0]           data_byte;
  } job_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } q_ctrl_t;

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

// ===== src/mlcd_front.sv =====
// ----------------------------------------------------------------------------
// mlcd_front
// Accepts input items, tracks frame position and vcom level, and turns each
// item into a job that lists the bytes it causes.
// ----------------------------------------------------------------------------
module mlcd_front #(
  parameter int MAX_ROW_BYTES = 64,
  parameter int MAX_LINES     = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [7:0]        pixel_byte_i,
  input  logic [5:0]        row_bytes_i,
  input  logic [7:0]        line_count_i,
  input  logic              q_full_i,
  output logic              push_o,
  output mlcd_pkg::job_t    job_o
);
  import mlcd_pkg::*;

  localparam logic [6:0] RbMax = 7'(MAX_ROW_BYTES);
  localparam logic [8:0] LcMax = 9'(MAX_LINES);

  logic [7:0] line_index_q, line_index_d;
  logic [5:0] byte_index_q, byte_index_d;
  logic       frame_open_q, frame_open_d;
  logic       vcom_q, vcom_d;

  logic       accept;
  logic [6:0] rb_eff;
  logic [8:0] lc_eff;
  logic [7:0] li;
  logic [5:0] bi;
  logic [6:0] bi_inc;
  logic [8:0] li_inc;
  logic       row_done;
  logic       frame_done;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign rb_eff = (row_bytes_i == '0 || {1'b0, row_bytes_i} > RbMax) ?
                  RbMax : {1'b0, row_bytes_i};
  assign lc_eff = (line_count_i == '0 || {1'b0, line_count_i} > LcMax) ?
                  LcMax : {1'b0, line_count_i};

  assign li         = frame_open_q ? line_index_q : '0;
  assign bi         = frame_open_q ? byte_index_q : '0;
  assign bi_inc     = {1'b0, bi} + 7'd1;
  assign li_inc     = {1'b0, li} + 9'd1;
  assign row_done   = bi_inc >= rb_eff;
  assign frame_done = row_done && (li_inc >= lc_eff);

  always_comb begin
    line_index_d = line_index_q;
    byte_index_d = byte_index_q;
    frame_open_d = frame_open_q;
    vcom_d       = vcom_q;
    push_o       = 1'b0;
    job_o        = '0;
    job_o.vcom   = vcom_q;
    if (accept) begin
      unique case (action_i)
        ACT_PIXEL: begin
          push_o                = 1'b1;
          job_o.mask[SLOT_CMD]  = !frame_open_q;
          job_o.mask[SLOT_LINE] = (bi == '0);
          job_o.mask[SLOT_DATA] = 1'b1;
          job_o.mask[SLOT_PAD]  = row_done;
          job_o.mask[SLOT_END]  = frame_done;
          job_o.line_byte       = reverse8(li_inc[7:0]);
          job_o.data_byte       = pixel_byte_i;
          byte_index_d          = row_done ? '0 : bi_inc[5:0];
          line_index_d          = frame_done ? '0 : (row_done ? li_inc[7:0] : li);
          frame_open_d          = !frame_done;
        end
        ACT_CLEAR: begin
          push_o               = 1'b1;
          job_o.clear          = 1'b1;
          job_o.mask[SLOT_CMD] = 1'b1;
          job_o.mask[SLOT_END] = 1'b1;
          line_index_d         = '0;
          byte_index_d         = '0;
          frame_open_d         = 1'b0;
        end
        ACT_TICK: begin
          push_o                = 1'b1;
          job_o.tick            = 1'b1;
          job_o.mask[SLOT_DATA] = 1'b1;
          vcom_d                = !vcom_q;
          job_o.vcom            = !vcom_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_index_q <= '0;
      byte_index_q <= '0;
      frame_open_q <= 1'b0;
      vcom_q       <= 1'b0;
    end else begin
      line_index_q <= line_index_d;
      byte_index_q <= byte_index_d;
      frame_open_q <= frame_open_d;
      vcom_q       <= vcom_d;
    end
  end

endmodule

// ===== src/mlcd_queue.sv =====
// ----------------------------------------------------------------------------
// mlcd_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module mlcd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mlcd_pkg::job_t    job_i,
  output logic              full_o,
  input  mlcd_pkg::q_ctrl_t ctrl_i,
  output mlcd_pkg::job_t    head_o,
  output logic              head_valid_o
);
  import mlcd_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  job_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o       = (count_q == (PtrW + 1)'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = ctrl_i.pop && ctrl_i.valid && head_valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

// ===== src/mlcd_back.sv =====
// ----------------------------------------------------------------------------
// mlcd_back
// Walks the byte slots of the job at the queue head into a registered output
// stage, one result per cycle while that stage is empty or being read.
// ----------------------------------------------------------------------------
module mlcd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mlcd_pkg::job_t    head_i,
  input  logic              head_valid_i,
  output mlcd_pkg::q_ctrl_t ctrl_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        spi_byte_o,
  output logic              byte_valid_o,
  output logic              transfer_end_o,
  output logic              last_of_run_o,
  output logic              vcom_level_o
);
  import mlcd_pkg::*;

  logic [NUM_SLOTS-1:0] done_q, done_d;
  logic [NUM_SLOTS-1:0] pend, sel;
  logic                 last, load;
  logic [7:0]           byte_sel;

  logic       out_valid_q;
  logic [7:0] spi_byte_q;
  logic       byte_valid_q, transfer_end_q, last_q, vcom_q;

  assign pend = head_i.mask & ~done_q;
  assign sel  = pend & (~pend + 1'b1);
  assign last = ((pend & ~sel) == '0);
  assign load = head_valid_i && (!out_valid_q || out_ready_i);

  assign ctrl_o.valid = load;
  assign ctrl_o.pop   = last;

  always_comb begin
    byte_sel = 8'h00;
    if (sel[SLOT_CMD]) begin
      byte_sel = head_i.clear ? CMD_CLEAR : CMD_WRITE;
    end else if (sel[SLOT_LINE]) begin
      byte_sel = head_i.line_byte;
    end else if (sel[SLOT_DATA]) begin
      byte_sel = head_i.tick ? 8'h00 : head_i.data_byte;
    end
  end

  always_comb begin
    done_d = done_q;
    if (load) begin
      done_d = last ? '0 : (done_q | sel);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      spi_byte_q     <= byte_sel;
      byte_valid_q   <= !head_i.tick;
      transfer_end_q <= sel[SLOT_END];
      last_q         <= last;
      vcom_q         <= head_i.vcom;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign spi_byte_o     = spi_byte_q;
  assign byte_valid_o   = byte_valid_q;
  assign transfer_end_o = transfer_end_q;
  assign last_of_run_o  = last_q;
  assign vcom_level_o   = vcom_q;

endmodule

// ===== src/memory_lcd_frame_serializer.sv =====
// ----------------------------------------------------------------------------
// memory_lcd_frame_serializer
// Pixel byte stream to memory LCD full-frame update byte stream.
// ----------------------------------------------------------------------------
// Each accepted item yields one to five result items, one per cycle from the
// back part while the receiver takes them: a pixel byte in mid-row gives one,
// the first byte of a row adds the bit-reversed line number, the first byte of
// a frame the write command, and the last byte of a row or frame its zero
// padding bytes; a clear gives two, a tick one, action 3 none. The input
// takes one item per cycle while the four-entry job queue has room, so a
// stream of pixel bytes runs at one item per cycle and slows only by receiver
// stalls and by the extra header and padding bytes of each row.
module memory_lcd_frame_serializer #(
  parameter int MAX_ROW_BYTES = 64,
  parameter int MAX_LINES     = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] pixel_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] spi_byte_o,
  output logic       byte_valid_o,
  output logic       transfer_end_o,
  output logic       last_of_run_o,
  output logic       vcom_level_o,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import mlcd_pkg::*;

  logic [5:0] row_bytes_q;
  logic [7:0] line_count_q;
  logic       push, q_full, head_valid;
  job_t       job, head;
  q_ctrl_t    q_ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q  <= 6'd16;
      line_count_q <= 8'd128;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROW_BYTES:  row_bytes_q  <= cfg_data_i[5:0];
        CFG_LINE_COUNT: line_count_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  mlcd_front #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES),
    .MAX_LINES    (MAX_LINES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .pixel_byte_i(pixel_byte_i),
    .row_bytes_i (row_bytes_q),
    .line_count_i(line_count_q),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (job)
  );

  mlcd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .job_i       (job),
    .full_o      (q_full),
    .ctrl_i      (q_ctrl),
    .head_o      (head),
    .head_valid_o(head_valid)
  );

  mlcd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_valid_i  (head_valid),
    .ctrl_o        (q_ctrl),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .spi_byte_o    (spi_byte_o),
    .byte_valid_o  (byte_valid_o),
    .transfer_end_o(transfer_end_o),
    .last_of_run_o (last_of_run_o),
    .vcom_level_o  (vcom_level_o)
  );

endmodule

// ===== src/mlcd_checker.sv =====
// ----------------------------------------------------------------------------
// mlcd_checker
// Port-level checks of the serializer output stream.
// ----------------------------------------------------------------------------
module mlcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] spi_byte_o,
  input logic       byte_valid_o,
  input logic       transfer_end_o,
  input logic       last_of_run_o
);

  // stalled item holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(spi_byte_o) && $stable(transfer_end_o))
    else $error("stalled output item changed");

  // a transfer ends on the last byte of its item
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && transfer_end_o |-> byte_valid_o && last_of_run_o)
    else $error("transfer end not on last valid byte");

  // closing byte is always zero
  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && transfer_end_o |-> spi_byte_o == 8'h00)
    else $error("transfer end byte not zero");

  // tick result stands alone
  a_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |->
      last_of_run_o && !transfer_end_o && spi_byte_o == 8'h00)
    else $error("malformed tick result");

endmodule

bind memory_lcd_frame_serializer mlcd_checker u_chk (.*);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the memory LCD frame serializer. A queue-fed driver
// offers action items and a clocked monitor compares every result item with
// a cycle-free model of the frame, row and vcom state, across several row
// length and line count settings, random idling on both sides, and one long
// receiver stall.
// ----------------------------------------------------------------------------
module testbench;
  import mlcd_pkg::*;

  localparam int ROW_LIMIT  = 64;
  localparam int LINE_LIMIT = 256;
  localparam int LIMIT      = 400000;
  localparam int HOLD_LEN   = 400;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] action;
    logic [7:0] pixel;
  } lcd_item_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       byte_valid;
    logic       transfer_end;
    logic       last_of_run;
    logic       vcom_level;
  } spi_rec_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic [1:0] action_i       = ACT_PIXEL;
  logic [7:0] pixel_byte_i   = 8'h00;
  logic       out_ready_i    = 1'b0;
  logic       cfg_we_i       = 1'b0;
  logic       cfg_index_i    = CFG_ROW_BYTES;
  logic [7:0] cfg_data_i     = 8'h00;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] spi_byte_o;
  logic       byte_valid_o;
  logic       transfer_end_o;
  logic       last_of_run_o;
  logic       vcom_level_o;

  lcd_item_t  frame_items[$];
  spi_rec_t   spi_expect_q[$];

  int         queued_cnt   = 0;
  int         accepted_cnt = 0;
  int         errors       = 0;
  int         cycle_cnt    = 0;
  int         send_idle    = 0;
  int         recv_idle    = 0;
  logic       in_taken     = 1'b0;
  logic       hold_req     = 1'b0;
  logic       hold_done    = 1'b0;
  int         hold_left    = 0;

  // model state
  logic [5:0] row_cfg   = 6'd16;
  logic [7:0] lines_cfg = 8'd128;
  int         cur_line  = 0;
  int         cur_byte  = 0;
  logic       frame_on  = 1'b0;
  logic       vcom_q    = 1'b0;

  memory_lcd_frame_serializer #(
    .MAX_ROW_BYTES(ROW_LIMIT),
    .MAX_LINES    (LINE_LIMIT)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .pixel_byte_i  (pixel_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .spi_byte_o    (spi_byte_o),
    .byte_valid_o  (byte_valid_o),
    .transfer_end_o(transfer_end_o),
    .last_of_run_o (last_of_run_o),
    .vcom_level_o  (vcom_level_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial forever #4 clk_i = ~clk_i;

  function automatic void push_byte(input logic [7:0] b, input logic vld, input logic fin);
    spi_rec_t rec;
    rec.spi_byte     = b;
    rec.byte_valid   = vld;
    rec.transfer_end = fin;
    rec.last_of_run  = 1'b0;
    rec.vcom_level   = vcom_q;
    spi_expect_q.push_back(rec);
  endfunction

  function automatic void predict_spi(input logic [1:0] act, input logic [7:0] pix);
    int         rb;
    int         lc;
    int         n0;
    logic [7:0] num;
    logic [7:0] rev;
    spi_rec_t   tail;
    n0 = spi_expect_q.size();
    case (act)
      ACT_TICK: begin
        vcom_q = ~vcom_q;
        push_byte(8'h00, 1'b0, 1'b0);
      end
      ACT_CLEAR: begin
        cur_line = 0;
        cur_byte = 0;
        frame_on = 1'b0;
        push_byte(CMD_CLEAR, 1'b1, 1'b0);
        push_byte(8'h00, 1'b1, 1'b1);
      end
      ACT_PIXEL: begin
        rb = (row_cfg == 6'd0) ? ROW_LIMIT : int'(row_cfg);
        lc = (lines_cfg == 8'd0) ? LINE_LIMIT : int'(lines_cfg);
        if (!frame_on) begin
          frame_on = 1'b1;
          cur_line = 0;
          cur_byte = 0;
          push_byte(CMD_WRITE, 1'b1, 1'b0);
        end
        if (cur_byte == 0) begin
          num = cur_line[7:0] + 8'd1;
          for (int k = 0; k < 8; k++) begin
            rev[k] = num[7-k];
          end
          push_byte(rev, 1'b1, 1'b0);
        end
        push_byte(pix, 1'b1, 1'b0);
        cur_byte++;
        if (cur_byte >= rb) begin
          cur_byte = 0;
          push_byte(8'h00, 1'b1, 1'b0);
          cur_line++;
          if (cur_line >= lc) begin
            cur_line = 0;
            frame_on = 1'b0;
            push_byte(8'h00, 1'b1, 1'b1);
          end
        end
        cur_byte = cur_byte & 63;
        cur_line = cur_line & 255;
      end
      default: ;
    endcase
    if (spi_expect_q.size() > n0) begin
      tail = spi_expect_q.pop_back();
      tail.last_of_run = 1'b1;
      spi_expect_q.push_back(tail);
    end
  endfunction

  // input driver
  always @(negedge clk_i) begin : drive_items
    lcd_item_t it;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (frame_items.size() != 0 && $urandom_range(99) >= send_idle) begin
        it = frame_items.pop_front();
        in_valid_i   <= 1'b1;
        action_i     <= it.action;
        pixel_byte_i <= it.pixel;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver with one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk_i) begin : check_spi
    spi_rec_t want;
    spi_rec_t got;
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_ROW_BYTES) begin
          row_cfg = cfg_data_i[5:0];
        end else begin
          lines_cfg = cfg_data_i;
        end
      end
      if (in_valid_i && in_ready_o) begin
        predict_spi(action_i, pixel_byte_i);
        accepted_cnt++;
      end
      if (out_valid_o && out_ready_i) begin
        got = {spi_byte_o, byte_valid_o, transfer_end_o, last_of_run_o, vcom_level_o};
        if (spi_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item byte %h valid %b end %b last %b vcom %b", $time,
                   got.spi_byte, got.byte_valid, got.transfer_end, got.last_of_run,
                   got.vcom_level);
        end else begin
          want = spi_expect_q.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected byte %h valid %b end %b last %b vcom %b",
                     $time, want.spi_byte, want.byte_valid, want.transfer_end,
                     want.last_of_run, want.vcom_level);
            $display("%0t:          actual   byte %h valid %b end %b last %b vcom %b",
                     $time, got.spi_byte, got.byte_valid, got.transfer_end,
                     got.last_of_run, got.vcom_level);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i); while (accepted_cnt != queued_cnt || spi_expect_q.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic push_item(input logic [1:0] act, input logic [7:0] pix);
    lcd_item_t it;
    it.action = act;
    it.pixel  = pix;
    frame_items.push_back(it);
    queued_cnt++;
  endtask

  task automatic run_phase(input logic [7:0] rb, input logic [7:0] lc, input int n,
                           input bit pix_only, input int s_idle, input int r_idle);
    int         r;
    logic [1:0] act;
    wait_drained();
    write_reg(CFG_ROW_BYTES, rb);
    write_reg(CFG_LINE_COUNT, lc);
    @(posedge clk_i);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (pix_only || r < 88) act = ACT_PIXEL;
      else if (r < 92) act = ACT_TICK;
      else if (r < 96) act = ACT_CLEAR;
      else act = ACT_UNUSED;
      push_item(act, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // two bytes per row, two rows per frame
    run_phase(8'd2, 8'd2, 0, 1'b0, 30, 70);
    push_item(ACT_TICK, 8'h00);
    push_item(ACT_PIXEL, 8'h00);
    push_item(ACT_PIXEL, 8'hFF);
    push_item(ACT_PIXEL, 8'h80);
    push_item(ACT_PIXEL, 8'h01);
    push_item(ACT_UNUSED, 8'hFF);
    push_item(ACT_TICK, 8'hFF);
    push_item(ACT_PIXEL, 8'h55);
    push_item(ACT_CLEAR, 8'h00);
    push_item(ACT_PIXEL, 8'hAA);
    push_item(ACT_PIXEL, 8'h0F);
    push_item(ACT_PIXEL, 8'hF0);
    push_item(ACT_PIXEL, 8'h3C);
    push_item(ACT_CLEAR, 8'hFF);
    push_item(ACT_CLEAR, 8'h00);
    push_item(ACT_UNUSED, 8'h00);
    push_item(ACT_TICK, 8'h00);

    run_phase(8'd3, 8'd4, 40, 1'b0, 30, 70);
    hold_req = 1'b1;
    run_phase(8'd1, 8'd1, 20, 1'b0, 30, 70);

    // upper data bits are dropped by the row length register
    run_phase(8'hC5, 8'd1, 30, 1'b0, 70, 30);
    run_phase(8'd63, 8'd255, 30, 1'b0, 70, 30);
    run_phase(8'h40, 8'd3, 20, 1'b0, 70, 30);

    // full 256-line frame with one byte per row, line number wraps to zero
    run_phase(8'd1, 8'd0, 260, 1'b1, 0, 0);
    run_phase(8'hFF, 8'hFF, 10, 1'b0, 0, 0);
    run_phase(8'd2, 8'd1, 20, 1'b0, 0, 0);

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (errors == 0 && spi_expect_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
